FILE: hw/rtl/dtq_pkg.sv
// Package with constants, codes and types of the deadline timer queue.
`default_nettype none
package dtq_pkg;
    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 52;
    localparam int HANDLE_W    = 8;
    localparam int MIN_W       = 20;
    localparam logic [MIN_W-1:0] MIN_DELAY_RESET = 20'd100;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_EXPIRE = 1'b1;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [2:0] ADDR_MIN_DELAY = 3'd0;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_ACK,
        ST_EXP_RD,
        ST_EXP_CMP,
        ST_EXP_LAST
    } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: sorted ring of timers in one memory.
`default_nettype none
// Timers sit in one synchronous memory as a ring sorted by (deadline, handle),
// with a head pointer and a fill count. A new input is taken only in idle,
// once the previous one has delivered its last beat to the output register.
// An insert walks from the tail toward the head, shifting each stored timer
// later than the new one up by one slot. The timer is placed at the head or
// behind a stored timer, and then the acknowledge is loaded. A full table
// goes straight to the acknowledge. An expire reads the head once per due
// timer. The walk closes when the table runs empty or the result cap is
// reached, or when a timer that is not yet due ends it. The single memory
// read port paces both walks. The acknowledge and each expired beat wait
// while the output register stays full.
module deadline_timer_queue
    import dtq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // timer_handle[7:0], deadline[59:8], now[111:60]
    input  wire logic [111:0] s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_handle[7:0], out_deadline[59:8], became_earliest[60], table_full[61],
    // arm_delay_us[113:62], zero[119:114]
    output logic [119:0]      m_axis_tdata,
    // kind[1:0]
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    entry_t mem [DEPTH];
    entry_t rdata_reg;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [RES_W-1:0] done_reg, done_next;
    logic             early_reg, early_next;
    logic             full_reg, full_next;
    logic             pend_reg, pend_next;
    entry_t           pend_ent_reg, pend_ent_next;
    logic             cmd_reg;
    entry_t           key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [MIN_W-1:0] min_delay_reg;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic             out_last_reg, out_last_next;
    logic [113:0]     out_data_reg, out_data_next;

    logic             in_fire, slot_free;
    logic [IDX_W-1:0] raddr, waddr;
    logic             wen;
    entry_t           wdata;
    logic [CNT_W-1:0] rd_off, wr_off;
    logic             greater, due;
    logic [TIME_W-1:0] delay_raw, delay;

    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] h,
                                                   input logic [CNT_W-1:0] o);
        logic [IDX_W+CNT_W-1:0] s;
        s = {{CNT_W{1'b0}}, h} + {{IDX_W{1'b0}}, o};
        if (s >= (IDX_W+CNT_W)'(DEPTH))
            s = s - (IDX_W+CNT_W)'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign pready        = 1'b1;
    assign prdata        = {{(32-MIN_W){1'b0}}, min_delay_reg};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    assign rd_off  = pos_reg - CNT_W'(1);
    assign wr_off  = pos_reg;
    assign greater = (rdata_reg.deadline > key_reg.deadline) ||
                     ((rdata_reg.deadline == key_reg.deadline) &&
                      (rdata_reg.handle > key_reg.handle));
    assign due     = (rdata_reg.deadline <= now_reg);
    assign delay_raw = (key_reg.deadline > now_reg) ? key_reg.deadline - now_reg
                                                    : '0;
    assign delay   = (delay_raw < {{(TIME_W-MIN_W){1'b0}}, min_delay_reg})
                     ? {{(TIME_W-MIN_W){1'b0}}, min_delay_reg} : delay_raw;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg         <= s_axis_tuser[0];
            key_reg.handle   <= s_axis_tdata[7:0];
            key_reg.deadline <= s_axis_tdata[59:8];
            now_reg         <= s_axis_tdata[111:60];
        end
        pend_ent_reg <= pend_ent_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            done_reg      <= '0;
            early_reg     <= 1'b0;
            full_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            min_delay_reg <= MIN_DELAY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            early_reg     <= early_next;
            full_reg      <= full_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && (paddr[2] == ADDR_MIN_DELAY[2]))
            begin
                min_delay_reg <= pwdata[MIN_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;
        early_next     = early_reg;
        full_next      = full_reg;
        pend_next      = pend_reg;
        pend_ent_next  = pend_ent_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        raddr          = ring_addr(head_reg, rd_off);
        waddr          = ring_addr(head_reg, wr_off);
        wen            = 1'b0;
        wdata          = key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next   = cnt_reg;
                    early_next = (cnt_reg == '0);
                    full_next  = (cnt_reg == CNT_W'(DEPTH));
                    done_next  = '0;
                    pend_next  = 1'b0;
                    if (s_axis_tuser[0] == CMD_EXPIRE)
                        state_next = ST_EXP_RD;
                    else if (cnt_reg == CNT_W'(DEPTH))
                        state_next = ST_INS_ACK;
                    else
                        state_next = ST_INS_RD;
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    wen        = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_INS_ACK;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (pos_reg == CNT_W'(1))
                    early_next = (key_reg.deadline < rdata_reg.deadline);
                wen = 1'b1;
                if (greater)
                begin
                    wdata      = rdata_reg;
                    pos_next   = pos_reg - CNT_W'(1);
                    state_next = ST_INS_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_INS_ACK;
                end
            end
            ST_INS_ACK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_last_next  = 1'b1;
                    out_data_next  = {(early_reg && !full_reg) ? delay : {TIME_W{1'b0}},
                                      full_reg, early_reg && !full_reg,
                                      key_reg.deadline, key_reg.handle};
                    state_next     = ST_IDLE;
                end
            end
            ST_EXP_RD:
            begin
                raddr = head_reg;
                if (cnt_reg == '0 || done_reg == RES_W'(MAX_RESULTS))
                    state_next = ST_EXP_LAST;
                else
                    state_next = ST_EXP_CMP;
            end
            ST_EXP_CMP:
            begin
                raddr = head_reg;
                if (!due)
                begin
                    state_next = ST_EXP_LAST;
                end
                else if (!pend_reg || slot_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_EXPIRED;
                        out_last_next  = 1'b0;
                        out_data_next  = {54'd0, pend_ent_reg.deadline,
                                          pend_ent_reg.handle};
                    end
                    pend_next     = 1'b1;
                    pend_ent_next = rdata_reg;
                    head_next     = ring_addr(head_reg, CNT_W'(1));
                    cnt_next      = cnt_reg - CNT_W'(1);
                    done_next     = done_reg + RES_W'(1);
                    state_next    = ST_EXP_RD;
                end
            end
            ST_EXP_LAST:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_reg)
                    begin
                        out_kind_next = KIND_EXPIRED;
                        out_data_next = {54'd0, pend_ent_reg.deadline,
                                         pend_ent_reg.handle};
                    end
                    else
                    begin
                        out_kind_next = KIND_NONE;
                        out_data_next = '0;
                    end
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("timer count exceeds table depth");

    a_full_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_ACK && full_reg) |-> (cnt_reg == CNT_W'(DEPTH)))
        else $error("full acknowledge with free slots");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_NONE) |-> m_axis_tlast)
        else $error("nothing-expired beat without last");

    a_insert_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_RD || state_reg == ST_INS_CMP) |-> (cmd_reg == CMD_INSERT))
        else $error("insert walk on an expire item");
endmodule
`default_nettype wire

FILE: verif/deadline_timer_queue_tb.sv
// Self-checking testbench for the deadline timer queue: table-driven and random beats.
`default_nettype none
module deadline_timer_queue_tb;
    import dtq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]          kind;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
        logic                earliest;
        logic                full;
        logic [TIME_W-1:0]   delay;
        logic                last;
    } timer_res_t;

    typedef struct {
        logic                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   now;
        logic                has_exp;
        timer_res_t          exp_res;
    } timer_req_t;

    localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    deadline_timer_queue u_top (.*);

    always #5 clk = ~clk;

    // shadow table and register
    logic [TIME_W-1:0]   sh_deadline[DEPTH];
    logic [HANDLE_W-1:0] sh_handle[DEPTH];
    int                  sh_count = 0;
    logic [MIN_W-1:0]    sh_min_delay = MIN_DELAY_RESET;

    timer_res_t pending_q[$];
    timer_res_t typed_q[$];
    int  typed_mark[$];
    int  err_count = 0;
    int  idle_cycles = 0;
    int  long_hold = 0;

    function automatic timer_res_t mk_res(logic [1:0] k, logic [7:0] h, logic [TIME_W-1:0] d,
                                          logic e, logic f, logic [TIME_W-1:0] dl, logic l);
        timer_res_t r;
        r.kind = k; r.handle = h; r.deadline = d; r.earliest = e;
        r.full = f; r.delay = dl; r.last = l;
        return r;
    endfunction

    task automatic predict_timer(input timer_req_t rq);
        int pos;
        int due;
        logic e;
        logic [TIME_W-1:0] dly;
        if (rq.cmd == CMD_INSERT)
        begin
            if (sh_count >= DEPTH)
            begin
                pending_q.push_back(mk_res(KIND_ACK, rq.handle, rq.deadline, 1'b0, 1'b1, '0,
                                           1'b1));
                return;
            end
            e = (sh_count == 0) || (rq.deadline < sh_deadline[0]);
            pos = 0;
            while (pos < sh_count && (sh_deadline[pos] < rq.deadline ||
                   (sh_deadline[pos] == rq.deadline && sh_handle[pos] <= rq.handle)))
                pos++;
            for (int i = sh_count; i > pos; i--)
            begin
                sh_deadline[i] = sh_deadline[i-1];
                sh_handle[i] = sh_handle[i-1];
            end
            sh_deadline[pos] = rq.deadline;
            sh_handle[pos] = rq.handle;
            sh_count++;
            dly = '0;
            if (e)
            begin
                dly = (rq.deadline > rq.now) ? rq.deadline - rq.now : '0;
                if (dly < {{(TIME_W-MIN_W){1'b0}}, sh_min_delay})
                    dly = {{(TIME_W-MIN_W){1'b0}}, sh_min_delay};
            end
            pending_q.push_back(mk_res(KIND_ACK, rq.handle, rq.deadline, e, 1'b0, dly, 1'b1));
        end
        else
        begin
            due = 0;
            while (due < sh_count && due < MAX_RESULTS && sh_deadline[due] <= rq.now)
                due++;
            if (due == 0)
            begin
                pending_q.push_back(mk_res(KIND_NONE, '0, '0, 1'b0, 1'b0, '0, 1'b1));
                return;
            end
            for (int i = 0; i < due; i++)
                pending_q.push_back(mk_res(KIND_EXPIRED, sh_handle[i], sh_deadline[i],
                                           1'b0, 1'b0, '0, i + 1 == due));
            for (int i = due; i < sh_count; i++)
            begin
                sh_deadline[i-due] = sh_deadline[i];
                sh_handle[i-due] = sh_handle[i];
            end
            sh_count -= due;
        end
    endtask

    // hold valid after the accepting edge; drop it only when a gap follows
    task automatic send_timer(input timer_req_t rq);
        int gap;
        int n0;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        n0 = pending_q.size();
        predict_timer(rq);
        if (rq.has_exp)
        begin
            typed_q.push_back(rq.exp_res);
            typed_mark.push_back(n0);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq.cmd;
        s_axis_tdata <= {rq.now, rq.deadline, rq.handle};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sh_min_delay = val[MIN_W-1:0];
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[TIME_W-1:0];
    endfunction

    function automatic timer_req_t req(logic c, logic [7:0] h, logic [TIME_W-1:0] d,
                                       logic [TIME_W-1:0] n);
        timer_req_t r;
        r.cmd = c; r.handle = h; r.deadline = d; r.now = n; r.has_exp = 1'b0;
        r.exp_res = '0;
        return r;
    endfunction

    // output side
    always @(posedge clk)
    begin
        timer_res_t got;
        timer_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = mk_res(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[59:8],
                         m_axis_tdata[60], m_axis_tdata[61], m_axis_tdata[113:62],
                         m_axis_tlast);
            if (pending_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10) $display("unexpected beat %p", got);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got !== want || m_axis_tdata[119:114] !== '0)
                begin
                    err_count++;
                    if (err_count <= 10) $display("mismatch exp %p got %p", want, got);
                end
                if (typed_mark.size() != 0 && typed_mark[0] == 0)
                begin
                    if (got !== typed_q[0])
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("table mismatch exp %p got %p", typed_q[0], got);
                    end
                    void'(typed_q.pop_front());
                    void'(typed_mark.pop_front());
                end
                foreach (typed_mark[i]) typed_mark[i]--;
            end
        end
    end

    initial
    begin
        int wait_n;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    timer_req_t dir_tab[$];

    initial
    begin
        timer_req_t r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        r = req(CMD_EXPIRE, 8'hFF, TMAX, TMAX); r.has_exp = 1'b1;
        r.exp_res = mk_res(KIND_NONE, '0, '0, 1'b0, 1'b0, '0, 1'b1); dir_tab.push_back(r);
        r = req(CMD_INSERT, 8'h00, TMAX, '0); r.has_exp = 1'b1;
        r.exp_res = mk_res(KIND_ACK, 8'h00, TMAX, 1'b1, 1'b0, TMAX, 1'b1); dir_tab.push_back(r);
        dir_tab.push_back(req(CMD_INSERT, 8'hFF, TMAX, TMAX));
        dir_tab.push_back(req(CMD_INSERT, 8'h10, 52'd500, 52'd450));
        dir_tab.push_back(req(CMD_INSERT, 8'h05, 52'd500, 52'd0));
        dir_tab.push_back(req(CMD_INSERT, 8'h05, 52'd500, 52'd0));
        dir_tab.push_back(req(CMD_INSERT, 8'h20, 52'd300, 52'd900));
        dir_tab.push_back(req(CMD_INSERT, 8'hAA, 52'd0, 52'd0));
        dir_tab.push_back(req(CMD_EXPIRE, 8'h00, 52'd0, 52'd500));
        dir_tab.push_back(req(CMD_EXPIRE, 8'h00, 52'd0, TMAX));
        for (int i = 0; i < 17; i++)
            dir_tab.push_back(req(CMD_INSERT, i[7:0], 52'd1000 + TIME_W'(i), 52'd0));
        foreach (dir_tab[i]) send_timer(dir_tab[i]);
        dir_tab.delete();
        for (int i = 0; i < 2; i++)
        begin
            r = req(CMD_EXPIRE, 8'h00, 52'd0, TMAX);
            send_timer(r);
        end

        wait_drained();
        apb_write(ADDR_MIN_DELAY, 32'd0);
        send_timer(req(CMD_INSERT, 8'h01, 52'd10, 52'd20));
        send_timer(req(CMD_EXPIRE, 8'h00, 52'd0, TMAX));
        wait_drained();
        apb_write(ADDR_MIN_DELAY, 32'hFFFFF);
        send_timer(req(CMD_INSERT, 8'h02, 52'd10, 52'd20));
        send_timer(req(CMD_EXPIRE, 8'h00, 52'd0, TMAX));
        wait_drained();
        apb_write(ADDR_MIN_DELAY, 32'd1000000);

        // back-pressure: hold the sink while the source keeps offering
        long_hold = 300;
        for (int i = 0; i < 12; i++)
            send_timer(req(CMD_INSERT, 8'($urandom_range(0, 255)),
                           52'd2000 + TIME_W'($urandom_range(0, 50)), 52'd1990));
        send_timer(req(CMD_EXPIRE, 8'h00, 52'd0, 52'd2100));

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            case (phase)
                0: apb_write(ADDR_MIN_DELAY, $urandom_range(0, 1000000));
                1: apb_write(ADDR_MIN_DELAY, 32'd0);
                2: apb_write(ADDR_MIN_DELAY, 32'd100);
                default: apb_write(ADDR_MIN_DELAY, 32'd1000000);
            endcase
            for (int i = 0; i < 110; i++)
            begin
                logic [TIME_W-1:0] base;
                int sel;
                base = (phase == 3) ? rand_time() : TIME_W'($urandom_range(0, 5000));
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    r = req(CMD_INSERT, 8'($urandom()), (phase == 3) ? rand_time()
                            : base + TIME_W'($urandom_range(0, 300)), base);
                else
                    r = req(CMD_EXPIRE, 8'($urandom()), rand_time(),
                            (phase == 3) ? rand_time()
                            : base + TIME_W'($urandom_range(0, 2000)));
                send_timer(r);
            end
        end
        send_timer(req(CMD_EXPIRE, 8'h00, 52'd0, TMAX));
        send_timer(req(CMD_EXPIRE, 8'h00, 52'd0, TMAX));

        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

FILE: deadline_timer_queue.f
hw/rtl/dtq_pkg.sv
hw/rtl/deadline_timer_queue.sv
verif/deadline_timer_queue_tb.sv
